[hw/rtl/websocket_frame_deframer_macros.svh]
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
`define WSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("wsd check failed");
`define WSD_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("wsd forbidden state");
`else
`define WSD_ASSERT(lbl, clk, rstn, prop)
`define WSD_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[hw/rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared codes, the front-to-back token and default sizes.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned LenBitsDefault    = 64;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [3:0] OP_CONT       = 4'h0;
  localparam logic [3:0] OP_TEXT       = 4'h1;
  localparam logic [3:0] OP_BIN        = 4'h2;
  localparam logic [3:0] OP_CONN_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING       = 4'h9;
  localparam logic [3:0] OP_PONG       = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OPCODE    = 3'd1,
    ERR_EXP_CONT  = 3'd2,
    ERR_UNEX_CONT = 3'd3,
    ERR_EMPTY     = 3'd4
  } err_e;

  typedef struct packed {
    logic       first;
    logic       payload;
    logic [7:0] raw;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       fin;
    logic       done;
    logic       msg;
    err_e       err;
  } tok_t;

  function automatic logic opcode_ok(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
           (op == OP_CONN_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

[hw/rtl/wsd_front.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Header parser: opcode checks, length, masking key, payload countdown.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module wsd_front #(
  parameter int unsigned LEN_BITS = wsd_pkg::LenBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          full_i,
  output logic          push_o,
  output wsd_pkg::tok_t tok_o
);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_LEN7    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  localparam logic [LEN_BITS-1:0] LenOne = {{(LEN_BITS-1){1'b0}}, 1'b1};

  phase_e              phase_q, phase_d;
  logic [3:0]          opcode_q, opcode_d;
  logic                fin_q, fin_d;
  logic                masked_q, masked_d;
  logic                cont_q, cont_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic                ovf_q, ovf_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [31:0]         key_q, key_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;
  logic [1:0]          kidx_q, kidx_d;

  logic [LEN_BITS-1:0] shifted;
  logic                ovf_sh;
  logic                do_known;
  logic [LEN_BITS-1:0] known_val;
  logic                do_enter;
  logic [LEN_BITS-1:0] enter_val;
  logic                end_f;
  wsd_pkg::err_e       err;
  wsd_pkg::tok_t       tok;

  assign push_o  = in_valid_i && !full_i;
  assign shifted = {len_q[LEN_BITS-9:0], rx_byte_i};
  assign ovf_sh  = ovf_q | (|len_q[LEN_BITS-1 -: 8]);

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    fin_d     = fin_q;
    masked_d  = masked_q;
    cont_d    = cont_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    rem_d     = rem_q;
    kidx_d    = kidx_q;
    do_known  = 1'b0;
    known_val = '0;
    do_enter  = 1'b0;
    enter_val = rem_q;
    end_f     = 1'b0;
    err       = wsd_pkg::ERR_NONE;
    tok       = '0;
    tok.raw   = rx_byte_i;

    unique case (phase_q)
      PH_FIRST: begin
        fin_d     = rx_byte_i[7];
        opcode_d  = rx_byte_i[3:0];
        masked_d  = 1'b0;
        key_d     = '0;
        len_d     = '0;
        ovf_d     = 1'b0;
        cnt_d     = '0;
        rem_d     = '0;
        kidx_d    = '0;
        tok.first = 1'b1;
        priority if (!wsd_pkg::opcode_ok(rx_byte_i[3:0])) begin
          err = wsd_pkg::ERR_OPCODE;
        end else if (cont_q && rx_byte_i[3:0] != wsd_pkg::OP_CONT) begin
          err = wsd_pkg::ERR_EXP_CONT;
        end else if (!cont_q && rx_byte_i[3:0] == wsd_pkg::OP_CONT) begin
          err = wsd_pkg::ERR_UNEX_CONT;
        end else begin
          cont_d  = !rx_byte_i[7];
          phase_d = PH_LEN7;
        end
      end
      PH_LEN7: begin
        masked_d = rx_byte_i[7];
        len_d    = '0;
        ovf_d    = 1'b0;
        cnt_d    = '0;
        priority if (rx_byte_i[6:0] < wsd_pkg::LEN7_EXT16) begin
          do_known  = 1'b1;
          known_val = {{(LEN_BITS-7){1'b0}}, rx_byte_i[6:0]};
        end else if (rx_byte_i[6:0] == wsd_pkg::LEN7_EXT16) begin
          phase_d = PH_EXT16;
        end else begin
          phase_d = PH_EXT64;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_d = shifted;
        ovf_d = ovf_sh;
        cnt_d = cnt_q + 3'd1;
        if ((phase_q == PH_EXT16 && cnt_q == 3'd1) ||
            (phase_q == PH_EXT64 && cnt_q == 3'd7)) begin
          do_known  = 1'b1;
          known_val = ovf_sh ? '1 : shifted;
        end
      end
      PH_KEY: begin
        key_d = key_q | ({24'd0, rx_byte_i} << {cnt_q[1:0], 3'b000});
        cnt_d = cnt_q + 3'd1;
        if (cnt_q[1:0] == 2'd3) begin
          do_enter = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        tok.payload = 1'b1;
        tok.key     = key_q[{kidx_q, 3'b000} +: 8];
        kidx_d      = kidx_q + 2'd1;
        rem_d       = rem_q - LenOne;
        if (rem_q == LenOne) begin
          end_f = 1'b1;
        end
      end
      default: begin
        phase_d = PH_FIRST;
      end
    endcase

    if (do_known) begin
      rem_d = known_val;
      if (masked_d) begin
        phase_d = PH_KEY;
        cnt_d   = '0;
      end else begin
        do_enter  = 1'b1;
        enter_val = known_val;
      end
    end

    if (do_enter) begin
      if (enter_val == '0) begin
        if (opcode_q == wsd_pkg::OP_CONT) begin
          err = wsd_pkg::ERR_EMPTY;
        end else begin
          end_f = 1'b1;
        end
      end else begin
        phase_d = PH_PAYLOAD;
        kidx_d  = '0;
      end
    end

    if (err != wsd_pkg::ERR_NONE) begin
      phase_d = PH_FIRST;
      cont_d  = 1'b0;
    end else if (end_f) begin
      tok.done = 1'b1;
      tok.msg  = fin_d;
      if (fin_d) begin
        cont_d = 1'b0;
      end
      phase_d = PH_FIRST;
    end

    tok.err    = err;
    tok.opcode = opcode_d;
    tok.fin    = fin_d;
  end

  assign tok_o = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      opcode_q <= '0;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      cont_q   <= 1'b0;
      len_q    <= '0;
      ovf_q    <= 1'b0;
      cnt_q    <= '0;
      key_q    <= '0;
      rem_q    <= '0;
      kidx_q   <= '0;
    end else if (push_o) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      cont_q   <= cont_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      rem_q    <= rem_d;
      kidx_q   <= kidx_d;
    end
  end

  `WSD_ASSERT(a_payload_has_bytes, clk_i, rst_ni, phase_q == PH_PAYLOAD |-> rem_q != '0)
  `WSD_NEVER(a_no_cont_mid_frame, clk_i, rst_ni, phase_q != PH_FIRST && opcode_q == wsd_pkg::OP_CONT && !cont_q && !fin_q)

endmodule

[hw/rtl/wsd_fifo.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer token queue
// Small register queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module wsd_fifo #(
  parameter int unsigned DEPTH = wsd_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsd_pkg::tok_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output wsd_pkg::tok_t data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  wsd_pkg::tok_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `WSD_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `WSD_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)

endmodule

[hw/rtl/wsd_back.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Unmask payload bytes, gather the close status, register the result.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module wsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  wsd_pkg::tok_t tok_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    byte_kind_o,
  output logic [7:0]    payload_byte_o,
  output logic [3:0]    frame_opcode_o,
  output logic          fin_flag_o,
  output logic          frame_done_o,
  output logic          message_done_o,
  output logic [2:0]    error_code_o,
  output logic [15:0]   close_status_o
);

  logic           valid_q;
  wsd_pkg::kind_e kind_q, kind_d;
  logic [7:0]     byte_q, byte_d;
  logic [3:0]     opcode_q;
  logic           fin_q, done_q, msg_q;
  wsd_pkg::err_e  err_q;
  logic [15:0]    st_q, st_d;
  logic [1:0]     seen_q, seen_d;
  logic [7:0]     plain;

  assign pop_o = !empty_i && (!valid_q || !out_stall_i);
  assign plain = tok_i.raw ^ tok_i.key;

  always_comb begin
    kind_d = wsd_pkg::KIND_HEADER;
    byte_d = '0;
    st_d   = tok_i.first ? '0 : st_q;
    seen_d = tok_i.first ? '0 : seen_q;
    if (tok_i.payload) begin
      byte_d = plain;
      if (tok_i.opcode == wsd_pkg::OP_CONN_CLOSE && seen_q < 2'd2) begin
        kind_d = wsd_pkg::KIND_STATUS;
        st_d   = {st_q[7:0], plain};
        seen_d = seen_q + 2'd1;
      end else begin
        kind_d = wsd_pkg::KIND_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      st_q    <= '0;
      seen_q  <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      st_q    <= st_d;
      seen_q  <= seen_d;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= kind_d;
      byte_q   <= byte_d;
      opcode_q <= tok_i.opcode;
      fin_q    <= tok_i.fin;
      done_q   <= tok_i.done;
      msg_q    <= tok_i.msg;
      err_q    <= tok_i.err;
    end
  end

  assign out_valid_o    = valid_q;
  assign byte_kind_o    = kind_q;
  assign payload_byte_o = byte_q;
  assign frame_opcode_o = opcode_q;
  assign fin_flag_o     = fin_q;
  assign frame_done_o   = done_q;
  assign message_done_o = msg_q;
  assign error_code_o   = err_q;
  assign close_status_o = st_q;

  `WSD_ASSERT(a_status_only_close, clk_i, rst_ni, valid_q && kind_q == wsd_pkg::KIND_STATUS |-> opcode_q == wsd_pkg::OP_CONN_CLOSE)

endmodule

[hw/rtl/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side frame parser with payload unmasking and close status capture.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received stream byte per transfer on rx_byte_i
//   (in_valid_i, in_stall_o). Output channel: exactly one result per input
//   byte (out_valid_o, out_stall_i) with its kind, unmasked byte, frame
//   opcode and FIN, frame and message completion, error code and the
//   close status accumulator.
//   An accepted byte passes the token queue and then the output register
//   on its way to the output port. Throughput: one byte per cycle while
//   in_stall_o is low, set by the header parser; the back end keeps pace.
//   A two-entry token queue sits between the parser and the output
//   register. While the receiver stalls, the output register holds and the
//   queue fills; in_stall_o rises once the queue is full.
//   Reset clears the parser to await the first header byte of a frame,
//   drops any open fragmented message and empties queue and output.
// ----------------------------------------------------------------------------

module websocket_frame_deframer #(
  parameter int unsigned LEN_BITS    = wsd_pkg::LenBitsDefault,
  parameter int unsigned QUEUE_DEPTH = wsd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  byte_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [3:0]  frame_opcode_o,
  output logic        fin_flag_o,
  output logic        frame_done_o,
  output logic        message_done_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] close_status_o
);

  logic          full;
  logic          push;
  logic          pop;
  logic          empty;
  wsd_pkg::tok_t front_tok;
  wsd_pkg::tok_t back_tok;

  assign in_stall_o = full;

  wsd_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .full_i     (full),
    .push_o     (push),
    .tok_o      (front_tok)
  );

  wsd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_tok),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (back_tok),
    .empty_o (empty)
  );

  wsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .tok_i          (back_tok),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_kind_o    (byte_kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_opcode_o (frame_opcode_o),
    .fin_flag_o     (fin_flag_o),
    .frame_done_o   (frame_done_o),
    .message_done_o (message_done_o),
    .error_code_o   (error_code_o),
    .close_status_o (close_status_o)
  );

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Streams received bytes through the deframer and checks every result field
// against a byte-level model of the frame parser kept in the bench. The
// stream opens with protocol corner cases (bad opcodes, continuation misuse,
// empty continuation, extended lengths, short close status), then carries
// mostly well-formed frames and fragmented messages with random content,
// mixed with broken frames and stray bytes. Both sides idle and stall at
// random; the receiver also holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ResetCycles  = 5;
  localparam int unsigned OpeningBytes = 25;
  localparam int unsigned RandomBytes  = 260;
  localparam int unsigned MaxDataBytes = 150;
  localparam int unsigned IdlePct      = 28;
  localparam int unsigned QuietFrom    = 200;
  localparam int unsigned QuietTo      = 500;
  localparam int unsigned HoldAt       = 60;
  localparam int unsigned HoldCycles   = 48;
  localparam int unsigned DrainAt      = 300;
  localparam int unsigned TailCycles   = 20;
  localparam int unsigned CycleLimit   = 200000;

  localparam logic [3:0]  OpReserved = 4'h3;
  localparam logic [6:0]  Len7Ext64  = 7'd127;
  localparam logic [63:0] LenLimit   = {64{1'b1}} >> (64 - wsd_pkg::LenBitsDefault);

  typedef enum logic [2:0] {
    PH_HEAD, PH_LEN7, PH_EXT16, PH_EXT64, PH_KEY, PH_DATA
  } parse_phase_e;

  typedef struct packed {
    wsd_pkg::kind_e kind;
    logic [7:0]     data;
    logic [3:0]     opcode;
    logic           fin;
    logic           done;
    logic           msg;
    wsd_pkg::err_e  err;
    logic [15:0]    status;
  } deframed_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  byte_kind_o;
  logic [7:0]  payload_byte_o;
  logic [3:0]  frame_opcode_o;
  logic        fin_flag_o;
  logic        frame_done_o;
  logic        message_done_o;
  logic [2:0]  error_code_o;
  logic [15:0] close_status_o;

  logic [7:0] rx_pending[$];
  deframed_t  deframed_due[$];
  deframed_t  want;
  int unsigned cycle_count  = 0;
  int unsigned fail_count   = 0;
  int unsigned bytes_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  logic        draining     = 1'b0;

  parse_phase_e ph;
  logic [3:0]   op_q;
  logic         fin_q;
  logic         masked_q;
  logic         msg_open;
  logic [63:0]  len_acc;
  logic [63:0]  remain;
  logic [2:0]   field_cnt;
  logic [31:0]  key_word;
  logic [1:0]   key_idx;
  logic [15:0]  status_q;
  logic [1:0]   status_cnt;
  deframed_t    res;

  websocket_frame_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_kind_o    (byte_kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_opcode_o (frame_opcode_o),
    .fin_flag_o     (fin_flag_o),
    .frame_done_o   (frame_done_o),
    .message_done_o (message_done_o),
    .error_code_o   (error_code_o),
    .close_status_o (close_status_o)
  );

  function automatic void deframer_reset();
    ph         = PH_HEAD;
    op_q       = wsd_pkg::OP_CONT;
    fin_q      = 1'b0;
    masked_q   = 1'b0;
    msg_open   = 1'b0;
    len_acc    = '0;
    remain     = '0;
    field_cnt  = '0;
    key_word   = '0;
    key_idx    = '0;
    status_q   = '0;
    status_cnt = '0;
  endfunction

  function automatic void abort_frame(input wsd_pkg::err_e code);
    res.err  = code;
    res.kind = wsd_pkg::KIND_HEADER;
    res.done = 1'b0;
    res.msg  = 1'b0;
    ph       = PH_HEAD;
    msg_open = 1'b0;
  endfunction

  function automatic void close_frame();
    res.done = 1'b1;
    res.msg  = fin_q;
    if (fin_q) begin
      msg_open = 1'b0;
    end
    ph = PH_HEAD;
  endfunction

  function automatic void start_payload();
    if (remain == 0) begin
      if (op_q == wsd_pkg::OP_CONT) begin
        abort_frame(wsd_pkg::ERR_EMPTY);
      end else begin
        close_frame();
      end
    end else begin
      ph      = PH_DATA;
      key_idx = '0;
    end
  endfunction

  function automatic void length_set(input logic [63:0] n);
    remain = (n > LenLimit) ? LenLimit : n;
    if (masked_q) begin
      ph        = PH_KEY;
      field_cnt = '0;
    end else begin
      start_payload();
    end
  endfunction

  function automatic deframed_t deframe_byte(input logic [7:0] b);
    logic [7:0] v;
    res = '0;
    case (ph)
      PH_HEAD: begin
        fin_q      = b[7];
        op_q       = b[3:0];
        masked_q   = 1'b0;
        key_word   = '0;
        len_acc    = '0;
        field_cnt  = '0;
        remain     = '0;
        key_idx    = '0;
        status_q   = '0;
        status_cnt = '0;
        if (!(op_q inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN,
                           wsd_pkg::OP_CONN_CLOSE, wsd_pkg::OP_PING,
                           wsd_pkg::OP_PONG})) begin
          abort_frame(wsd_pkg::ERR_OPCODE);
        end else if (msg_open && op_q != wsd_pkg::OP_CONT) begin
          abort_frame(wsd_pkg::ERR_EXP_CONT);
        end else if (!msg_open && op_q == wsd_pkg::OP_CONT) begin
          abort_frame(wsd_pkg::ERR_UNEX_CONT);
        end else begin
          msg_open = !fin_q;
          ph       = PH_LEN7;
        end
      end
      PH_LEN7: begin
        masked_q  = b[7];
        len_acc   = '0;
        field_cnt = '0;
        if (b[6:0] < wsd_pkg::LEN7_EXT16) begin
          length_set(64'(b[6:0]));
        end else if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
          ph = PH_EXT16;
        end else begin
          ph = PH_EXT64;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_acc   = {len_acc[55:0], b};
        field_cnt = field_cnt + 3'd1;
        if (field_cnt == ((ph == PH_EXT16) ? 3'd2 : 3'd0)) begin
          length_set(len_acc);
        end
      end
      PH_KEY: begin
        key_word  = key_word | (32'(b) << (8 * field_cnt[1:0]));
        field_cnt = field_cnt + 3'd1;
        if (field_cnt >= 3'd4) begin
          start_payload();
        end
      end
      PH_DATA: begin
        v        = b ^ key_word[8 * key_idx +: 8];
        key_idx  = key_idx + 2'd1;
        res.data = v;
        if (op_q == wsd_pkg::OP_CONN_CLOSE && status_cnt < 2'd2) begin
          res.kind   = wsd_pkg::KIND_STATUS;
          status_q   = {status_q[7:0], v};
          status_cnt = status_cnt + 2'd1;
        end else begin
          res.kind = wsd_pkg::KIND_PAYLOAD;
        end
        if (remain != 0) begin
          remain = remain - 64'd1;
        end
        if (remain == 0) begin
          close_frame();
        end
      end
      default: begin
        ph = PH_HEAD;
      end
    endcase
    res.opcode = op_q;
    res.fin    = fin_q;
    res.status = status_q;
    return res;
  endfunction

  // Queue the byte and advance the parser model so the generator tracks the phase.
  function automatic void queue_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    void'(deframe_byte(b));
  endfunction

  function automatic logic [63:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      return 64'($urandom_range(126, 140));
    end else if (r < 20) begin
      return 64'($urandom_range(13, 40));
    end
    return 64'($urandom_range(0, 12));
  endfunction

  task automatic push_frame(input logic fin, input logic [3:0] op, input logic [63:0] len);
    logic        masked;
    int unsigned enc;
    longint unsigned i;
    masked = ($urandom_range(0, 9) < 7);
    enc    = $urandom_range(0, 99);
    queue_byte({fin, 3'($urandom), op});
    if (ph == PH_HEAD) begin
      return;
    end
    if (len < 126 && enc < 70) begin
      queue_byte({masked, len[6:0]});
    end else if (len < 65536 && enc < 85) begin
      queue_byte({masked, wsd_pkg::LEN7_EXT16});
      queue_byte(len[15:8]);
      queue_byte(len[7:0]);
    end else begin
      queue_byte({masked, Len7Ext64});
      for (int k = 7; k >= 0; k--) begin
        queue_byte(len[8 * k +: 8]);
      end
    end
    if (masked) begin
      repeat (4) queue_byte(8'($urandom));
    end
    for (i = 0; i < len && i < MaxDataBytes; i++) begin
      queue_byte(8'($urandom));
    end
  endtask

  function automatic logic quiet_stretch();
    return cycle_count >= QuietFrom && cycle_count < QuietTo;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Input side: hold the byte until transferred, then offer the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        deframed_due.push_back(deframe_byte(rx_byte_i));
        bytes_taken++;
        if (bytes_taken == DrainAt) begin
          draining = 1'b1;
        end
      end
      if (draining && deframed_due.size() == 0) begin
        draining = 1'b0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rx_pending.size() != 0 && !draining &&
            (quiet_stretch() || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: check each transfer, stall at random, hold off once at length.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (deframed_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0h byte %0h",
                   $time, byte_kind_o, payload_byte_o);
          fail_count++;
        end else begin
          want = deframed_due.pop_front();
          check_field("byte_kind", 16'(want.kind), 16'(byte_kind_o));
          check_field("payload_byte", 16'(want.data), 16'(payload_byte_o));
          check_field("frame_opcode", 16'(want.opcode), 16'(frame_opcode_o));
          check_field("fin_flag", 16'(want.fin), 16'(fin_flag_o));
          check_field("frame_done", 16'(want.done), 16'(frame_done_o));
          check_field("message_done", 16'(want.msg), 16'(message_done_o));
          check_field("error_code", 16'(want.err), 16'(error_code_o));
          check_field("close_status", want.status, close_status_o);
          results_seen++;
          if (results_seen == HoldAt) begin
            hold_left = HoldCycles;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet_stretch() && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  initial begin
    int unsigned roll;
    int unsigned nfrag;
    int unsigned total_bytes;
    logic [3:0]  data_op;
    logic [3:0]  ctl_op;
    logic [7:0]  opening [OpeningBytes];
    opening = '{
      {4'h0, OpReserved},
      {4'h0, wsd_pkg::OP_CONT},
      {4'h0, wsd_pkg::OP_TEXT}, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      {4'h8, wsd_pkg::OP_BIN},
      {4'h0, wsd_pkg::OP_BIN}, 8'h01, 8'hFF,
      {4'h0, wsd_pkg::OP_CONT}, 8'h00,
      {4'h8, wsd_pkg::OP_CONN_CLOSE}, {1'b0, Len7Ext64},
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
      8'hAB
    };
    deframer_reset();
    foreach (opening[k]) begin
      queue_byte(opening[k]);
    end

    while (rx_pending.size() < OpeningBytes + RandomBytes) begin
      roll    = $urandom_range(0, 99);
      data_op = $urandom_range(0, 1) ? wsd_pkg::OP_TEXT : wsd_pkg::OP_BIN;
      case ($urandom_range(0, 2))
        0:       ctl_op = wsd_pkg::OP_CONN_CLOSE;
        1:       ctl_op = wsd_pkg::OP_PING;
        default: ctl_op = wsd_pkg::OP_PONG;
      endcase
      if (roll < 50) begin
        nfrag = $urandom_range(1, 3);
        for (int f = 0; f < nfrag; f++) begin
          if (f != 0 && $urandom_range(0, 9) == 0) begin
            push_frame(1'b1, ctl_op, 64'($urandom_range(0, 3)));
          end
          push_frame(f == nfrag - 1, (f == 0) ? data_op : wsd_pkg::OP_CONT, pick_len());
        end
      end else if (roll < 72) begin
        push_frame($urandom_range(0, 9) != 0, ctl_op, 64'($urandom_range(0, 4)));
      end else if (roll < 80) begin
        push_frame(1'b0, data_op, pick_len());
        push_frame(1'($urandom_range(0, 1)), wsd_pkg::OP_CONT, '0);
      end else if (roll < 88) begin
        push_frame(1'b1, wsd_pkg::OP_CONT, pick_len());
      end else begin
        queue_byte(8'($urandom));
      end
      // Bring a broken frame back to a frame boundary.
      while (ph != PH_HEAD) begin
        case (ph)
          PH_LEN7:            queue_byte({1'($urandom), 7'($urandom_range(0, 12))});
          PH_EXT16, PH_EXT64: queue_byte(8'h00);
          default:            queue_byte(8'($urandom));
        endcase
      end
    end
    // Frame with the largest length; it stays open to the end of the run.
    push_frame(1'b1, msg_open ? wsd_pkg::OP_CONT : wsd_pkg::OP_BIN, '1);
    total_bytes = rx_pending.size();
    deframer_reset();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < total_bytes) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[websocket_frame_deframer.f]
+incdir+hw/rtl
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_fifo.sv
hw/rtl/wsd_back.sv
hw/rtl/websocket_frame_deframer.sv
sim/tb_top.sv
